// ----- sv/cop_pkg.sv -----
// Shared types and constants for the circle overlap push-out pipeline.
package cop_pkg;

    localparam int COORD_W         = 24;
    localparam int RAD_W           = 23;
    localparam int SCALE_W         = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int WRAD_W          = RAD_W + SCALE_W + 1 - (SCALE_FRAC_BITS + 1);
    localparam int RSUM_W          = WRAD_W + 1;
    localparam int SQ_W            = 2 * DIFF_W;
    localparam int ROOT_W          = DIFF_W;
    localparam int SQRT_STAGES     = ROOT_W;
    localparam int QUO_W           = RSUM_W;
    localparam int DIV_STAGES      = QUO_W;
    localparam int PROD_W          = DIFF_W + RSUM_W;
    localparam int HALF_W          = RSUM_W / 2;
    localparam int RSQ_BITS        = 26;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_center_x;
        logic signed [COORD_W-1:0] a_center_y;
        logic        [RAD_W-1:0]   a_base_radius;
        logic        [SCALE_W-1:0] a_scale_x;
        logic        [SCALE_W-1:0] a_scale_y;
        logic signed [COORD_W-1:0] b_center_x;
        logic signed [COORD_W-1:0] b_center_y;
        logic        [RAD_W-1:0]   b_base_radius;
        logic        [SCALE_W-1:0] b_scale_x;
        logic        [SCALE_W-1:0] b_scale_y;
    } in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] new_b_x;
        logic signed [COORD_W-1:0] new_b_y;
    } out_t;

    // per-item context carried down the pipe
    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic        [RSUM_W-1:0]  rsum;
        logic                      hit;
        logic        [ROOT_W-1:0]  len;
        logic                      push;
    } ctx_t;

endpackage

// ----- sv/circle_overlap_push_out_core.sv -----
// Circle-circle overlap test and push-out of circle B, fully pipelined.
// Pipeline: 4 front stages + 25 square-root stages + 4 scaling stages + 32 divide
// stages + 1 output stage. Throughput: one beat per cycle while the output is not stalled.
// The square root and the divider resolve one result bit per stage.
// A stall on the output freezes the whole pipe; bubbles pass without cost.
// Reset (rst_n low, async) clears all valid bits; data registers are not reset.
module circle_overlap_push_out_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  cop_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output cop_pkg::out_t  out_data
);

    localparam int CW = cop_pkg::COORD_W;
    localparam int DW = cop_pkg::DIFF_W;
    localparam int WW = cop_pkg::WRAD_W;
    localparam int RW = cop_pkg::RSUM_W;
    localparam int SW = cop_pkg::SQ_W;
    localparam int TW = cop_pkg::ROOT_W;
    localparam int NS = cop_pkg::SQRT_STAGES;
    localparam int QW = cop_pkg::QUO_W;
    localparam int ND = cop_pkg::DIV_STAGES;
    localparam int PW = cop_pkg::PROD_W;
    localparam int HW = cop_pkg::HALF_W;
    localparam int KW = cop_pkg::RSQ_BITS;
    localparam int SHW = cop_pkg::SCALE_FRAC_BITS + 1;
    localparam int MW = cop_pkg::RAD_W + cop_pkg::SCALE_W + 1;
    localparam int OW = QW + 2;

    logic en;
    logic out_valid_reg;
    cop_pkg::out_t out_data_reg;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- stage 1: differences, world radii
    logic s1_v_reg;
    cop_pkg::ctx_t s1_ctx_reg, s1_ctx_next;
    logic [WW-1:0] s1_wra_reg, s1_wrb_reg, s1_wra_next, s1_wrb_next;

    always_comb
    begin
        logic [MW-1:0] pa, pb;
        pa = MW'(in_data.a_base_radius) * MW'(MW'(in_data.a_scale_x) + MW'(in_data.a_scale_y));
        pb = MW'(in_data.b_base_radius) * MW'(MW'(in_data.b_scale_x) + MW'(in_data.b_scale_y));
        s1_wra_next      = pa[MW-1:SHW];
        s1_wrb_next      = pb[MW-1:SHW];
        s1_ctx_next      = '0;
        s1_ctx_next.bx   = in_data.b_center_x;
        s1_ctx_next.by   = in_data.b_center_y;
        s1_ctx_next.dx   = DW'(in_data.b_center_x) - DW'(in_data.a_center_x);
        s1_ctx_next.dy   = DW'(in_data.b_center_y) - DW'(in_data.a_center_y);
    end

    // ---------------- stage 2: radius sum, squares
    logic s2_v_reg;
    cop_pkg::ctx_t s2_ctx_reg, s2_ctx_next;
    logic [SW-1:0] s2_sqx_reg, s2_sqy_reg, s2_sqx_next, s2_sqy_next;

    always_comb
    begin
        logic [DW-1:0] ax, ay;
        ax = s1_ctx_reg.dx[DW-1] ? DW'(-s1_ctx_reg.dx) : DW'(s1_ctx_reg.dx);
        ay = s1_ctx_reg.dy[DW-1] ? DW'(-s1_ctx_reg.dy) : DW'(s1_ctx_reg.dy);
        s2_sqx_next      = SW'(ax) * SW'(ax);
        s2_sqy_next      = SW'(ay) * SW'(ay);
        s2_ctx_next      = s1_ctx_reg;
        s2_ctx_next.rsum = RW'(s1_wra_reg) + RW'(s1_wrb_reg);
    end

    // ---------------- stage 3: distance squared, radius sum squared
    logic s3_v_reg;
    cop_pkg::ctx_t s3_ctx_reg;
    logic [SW-1:0] s3_d2_reg, s3_d2_next;
    logic [2*KW-1:0] s3_rs2_reg, s3_rs2_next;
    logic s3_big_reg, s3_big_next;

    always_comb
    begin
        s3_d2_next  = s2_sqx_reg + s2_sqy_reg;
        s3_rs2_next = (2*KW)'(s2_ctx_reg.rsum[KW-1:0]) * (2*KW)'(s2_ctx_reg.rsum[KW-1:0]);
        s3_big_next = |s2_ctx_reg.rsum[RW-1:KW];
    end

    // ---------------- square root, one root bit per stage
    logic              sq_v_reg    [0:NS];
    cop_pkg::ctx_t     sq_ctx_reg  [0:NS];
    logic [SW-1:0]     sq_d2_reg   [0:NS];
    logic [TW:0]       sq_rem_reg  [0:NS];
    logic [TW-1:0]     sq_root_reg [0:NS];
    cop_pkg::ctx_t     sq0_ctx_next;
    logic [TW:0]       sq_rem_next  [1:NS];
    logic [TW-1:0]     sq_root_next [1:NS];

    always_comb
    begin
        sq0_ctx_next     = s3_ctx_reg;
        sq0_ctx_next.hit = s3_big_reg || ((2*KW)'(s3_d2_reg) < s3_rs2_reg);
    end

    always_comb
    begin
        logic [TW+2:0] cur, trial;
        for (int k = 1; k <= NS; k++)
        begin
            cur   = {sq_rem_reg[k-1], sq_d2_reg[k-1][2*(NS-k) +: 2]};
            trial = (TW+3)'({sq_root_reg[k-1], 2'b01});
            if (cur >= trial)
            begin
                sq_rem_next[k]  = (TW+1)'(cur - trial);
                sq_root_next[k] = {sq_root_reg[k-1][TW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = cur[TW:0];
                sq_root_next[k] = {sq_root_reg[k-1][TW-2:0], 1'b0};
            end
        end
    end

    // ---------------- overlap amount and magnitudes
    logic p_v_reg;
    cop_pkg::ctx_t p_ctx_reg, p_ctx_next;
    logic [RW-1:0] p_s_reg, p_s_next;
    logic [DW-1:0] p_mx_reg, p_my_reg, p_mx_next, p_my_next;

    always_comb
    begin
        p_ctx_next      = sq_ctx_reg[NS];
        p_ctx_next.len  = sq_root_reg[NS];
        p_ctx_next.push = sq_ctx_reg[NS].hit && (sq_root_reg[NS] != '0);
        p_s_next        = sq_ctx_reg[NS].rsum - RW'(sq_root_reg[NS]);
        p_mx_next = sq_ctx_reg[NS].dx[DW-1] ? DW'(-sq_ctx_reg[NS].dx) : DW'(sq_ctx_reg[NS].dx);
        p_my_next = sq_ctx_reg[NS].dy[DW-1] ? DW'(-sq_ctx_reg[NS].dy) : DW'(sq_ctx_reg[NS].dy);
    end

    // ---------------- partial products, then sum
    logic m1_v_reg;
    cop_pkg::ctx_t m1_ctx_reg;
    logic [PW-1:0] m1_xl_reg, m1_xh_reg, m1_yl_reg, m1_yh_reg;
    logic m2_v_reg;
    cop_pkg::ctx_t m2_ctx_reg;
    logic [PW-1:0] m2_nx_reg, m2_ny_reg;

    // ---------------- divide, one quotient bit per stage
    logic              dv_v_reg   [0:ND];
    cop_pkg::ctx_t     dv_ctx_reg [0:ND];
    logic [PW-1:0]     dv_nx_reg  [0:ND];
    logic [PW-1:0]     dv_ny_reg  [0:ND];
    logic [TW-1:0]     dv_rx_reg  [0:ND];
    logic [TW-1:0]     dv_ry_reg  [0:ND];
    logic [QW-1:0]     dv_qx_reg  [0:ND];
    logic [QW-1:0]     dv_qy_reg  [0:ND];
    logic [TW-1:0]     dv_rx_next [1:ND];
    logic [TW-1:0]     dv_ry_next [1:ND];
    logic [QW-1:0]     dv_qx_next [1:ND];
    logic [QW-1:0]     dv_qy_next [1:ND];

    always_comb
    begin
        logic [TW:0] cx, cy, lw;
        for (int k = 1; k <= ND; k++)
        begin
            lw = {1'b0, dv_ctx_reg[k-1].len};
            cx = {dv_rx_reg[k-1], dv_nx_reg[k-1][ND-k]};
            cy = {dv_ry_reg[k-1], dv_ny_reg[k-1][ND-k]};
            if (cx >= lw)
            begin
                dv_rx_next[k] = TW'(cx - lw);
                dv_qx_next[k] = {dv_qx_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                dv_rx_next[k] = cx[TW-1:0];
                dv_qx_next[k] = {dv_qx_reg[k-1][QW-2:0], 1'b0};
            end
            if (cy >= lw)
            begin
                dv_ry_next[k] = TW'(cy - lw);
                dv_qy_next[k] = {dv_qy_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                dv_ry_next[k] = cy[TW-1:0];
                dv_qy_next[k] = {dv_qy_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // ---------------- apply push and saturate
    cop_pkg::out_t out_data_next;

    always_comb
    begin
        logic signed [OW-1:0] sx, sy;
        cop_pkg::ctx_t c;
        c = dv_ctx_reg[ND];
        if (c.dx[DW-1])
            sx = OW'(c.bx) - $signed(OW'(dv_qx_reg[ND]));
        else
            sx = OW'(c.bx) + $signed(OW'(dv_qx_reg[ND]));
        if (c.dy[DW-1])
            sy = OW'(c.by) - $signed(OW'(dv_qy_reg[ND]));
        else
            sy = OW'(c.by) + $signed(OW'(dv_qy_reg[ND]));
        out_data_next.hit     = c.hit;
        out_data_next.new_b_x = c.bx;
        out_data_next.new_b_y = c.by;
        if (c.push)
        begin
            if (sx > $signed(OW'({1'b0, {(CW-1){1'b1}}})))
                out_data_next.new_b_x = {1'b0, {(CW-1){1'b1}}};
            else if (sx < $signed({{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}}))
                out_data_next.new_b_x = {1'b1, {(CW-1){1'b0}}};
            else
                out_data_next.new_b_x = sx[CW-1:0];
            if (sy > $signed(OW'({1'b0, {(CW-1){1'b1}}})))
                out_data_next.new_b_y = {1'b0, {(CW-1){1'b1}}};
            else if (sy < $signed({{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}}))
                out_data_next.new_b_y = {1'b1, {(CW-1){1'b0}}};
            else
                out_data_next.new_b_y = sy[CW-1:0];
        end
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            m1_v_reg      <= 1'b0;
            m2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
                sq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= ND; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg      <= in_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            sq_v_reg[0]   <= s3_v_reg;
            for (int k = 1; k <= NS; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            p_v_reg       <= sq_v_reg[NS];
            m1_v_reg      <= p_v_reg;
            m2_v_reg      <= m1_v_reg;
            dv_v_reg[0]   <= m2_v_reg;
            for (int k = 1; k <= ND; k++)
                dv_v_reg[k] <= dv_v_reg[k-1];
            out_valid_reg <= dv_v_reg[ND];
        end
    end

    // ---------------- data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctx_reg <= s1_ctx_next;
            s1_wra_reg <= s1_wra_next;
            s1_wrb_reg <= s1_wrb_next;

            s2_ctx_reg <= s2_ctx_next;
            s2_sqx_reg <= s2_sqx_next;
            s2_sqy_reg <= s2_sqy_next;

            s3_ctx_reg <= s2_ctx_reg;
            s3_d2_reg  <= s3_d2_next;
            s3_rs2_reg <= s3_rs2_next;
            s3_big_reg <= s3_big_next;

            sq_ctx_reg[0]  <= sq0_ctx_next;
            sq_d2_reg[0]   <= s3_d2_reg;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 1; k <= NS; k++)
            begin
                sq_ctx_reg[k]  <= sq_ctx_reg[k-1];
                sq_d2_reg[k]   <= sq_d2_reg[k-1];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
            end

            p_ctx_reg <= p_ctx_next;
            p_s_reg   <= p_s_next;
            p_mx_reg  <= p_mx_next;
            p_my_reg  <= p_my_next;

            // split the overlap in halves to keep each multiplier narrow
            m1_ctx_reg <= p_ctx_reg;
            m1_xl_reg  <= PW'(p_mx_reg) * PW'(p_s_reg[HW-1:0]);
            m1_xh_reg  <= PW'(p_mx_reg) * PW'(p_s_reg[RW-1:HW]);
            m1_yl_reg  <= PW'(p_my_reg) * PW'(p_s_reg[HW-1:0]);
            m1_yh_reg  <= PW'(p_my_reg) * PW'(p_s_reg[RW-1:HW]);

            m2_ctx_reg <= m1_ctx_reg;
            m2_nx_reg  <= m1_xl_reg + (m1_xh_reg << HW);
            m2_ny_reg  <= m1_yl_reg + (m1_yh_reg << HW);

            // quotient fits QW bits, so the top bits are already below len
            dv_ctx_reg[0] <= m2_ctx_reg;
            dv_nx_reg[0]  <= m2_nx_reg;
            dv_ny_reg[0]  <= m2_ny_reg;
            dv_rx_reg[0]  <= m2_nx_reg[PW-1:QW];
            dv_ry_reg[0]  <= m2_ny_reg[PW-1:QW];
            dv_qx_reg[0]  <= '0;
            dv_qy_reg[0]  <= '0;
            for (int k = 1; k <= ND; k++)
            begin
                dv_ctx_reg[k] <= dv_ctx_reg[k-1];
                dv_nx_reg[k]  <= dv_nx_reg[k-1];
                dv_ny_reg[k]  <= dv_ny_reg[k-1];
                dv_rx_reg[k]  <= dv_rx_next[k];
                dv_ry_reg[k]  <= dv_ry_next[k];
                dv_qx_reg[k]  <= dv_qx_next[k];
                dv_qy_reg[k]  <= dv_qy_next[k];
            end

            out_data_reg <= out_data_next;
        end
    end

endmodule
